[rtl/bpra_pkg.sv]
// shared types and constants for the beam position raster average unit
package bpra_pkg;

  localparam int MAX_WINDOW_DEF = 512;
  localparam int WIN_W = 10;
  // sum of up to 2**WIN_W - 1 samples of 32 bits, whatever the ram depth
  localparam int SUM_W = 32 + WIN_W;
  localparam int DIV_STEPS = SUM_W;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_RATIO  = 3'd1;
  localparam logic [2:0] REG_WINDOW = 3'd2;
  localparam logic [2:0] REG_CX     = 3'd3;
  localparam logic [2:0] REG_CY     = 3'd4;
  localparam logic [2:0] REG_SX     = 3'd5;
  localparam logic [2:0] REG_SY     = 3'd6;

  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROJ_X,
    ST_PROJ_Y,
    ST_READ,
    ST_SUM,
    ST_DIV_X,
    ST_DIV_Y,
    ST_OFF_X,
    ST_OFF_Y,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [SUM_W+8:0] v, output logic clip);
    clip = 1'b0;
    if (v > $signed({{(SUM_W-22){1'b0}}, 31'h7fffffff})) begin
      clip = 1'b1;
      sat32 = 32'h7fffffff;
    end else if (v < -$signed({{(SUM_W-22){1'b0}}, 31'h7fffffff}) - 1) begin
      clip = 1'b1;
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[rtl/beam_position_raster_average_unit.sv]
// top level: projection, windowed average and raster offset of beam position
// flow: projection, ram read and sum, two 42-step serial divisions, raster offset,
// then the result transaction, which holds while out_stall is high
// a new input is accepted only after the previous result has been taken
// reset: synchronous, clears state and configuration registers to defaults and restarts averaging
// window ram is not cleared; warmup writes each entry before it is read
module beam_position_raster_average_unit import bpra_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] mon_a_x,
  input  logic signed [31:0] mon_a_y,
  input  logic signed [31:0] mon_b_x,
  input  logic signed [31:0] mon_b_y,
  input  logic [15:0]        up_raster_x,
  input  logic [15:0]        up_raster_y,
  input  logic [15:0]        down_raster_x,
  input  logic [15:0]        down_raster_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] beam_x,
  output logic signed [31:0] beam_y,
  output logic               clipped
);
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [1:0]         raster_mode;
  logic signed [23:0] projection_ratio;
  logic [9:0]         window_length;
  logic signed [16:0] center_x, center_y;
  logic signed [31:0] scale_x, scale_y;

  state_t state, state_next;

  logic signed [31:0] a_x, a_y, b_x, b_y;
  logic [15:0]        ux, uy, dx, dy;
  logic signed [31:0] px, py;
  logic               clip;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [CW-1:0]      fill_count;
  logic [AW-1:0]      oldest_pointer;
  logic [CW-1:0]      count;
  logic               full;
  logic signed [SUM_W-1:0] avg_x;
  logic signed [SUM_W+8:0] acc;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [CW-1:0] eff_w;
  always_comb begin
    if (window_length == 10'd0) eff_w = CW'(1);
    else if ({22'd0, window_length} > 32'(MAX_WINDOW)) eff_w = CW'(MAX_WINDOW);
    else eff_w = CW'(window_length);
  end

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [31:0]       old_x, old_y;
  bpra_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW)) u_ram_x (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(px), .rdata(old_x));
  bpra_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW)) u_ram_y (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(py), .rdata(old_y));

  assign full     = fill_count >= eff_w;
  assign ram_addr = full ? oldest_pointer : fill_count[AW-1:0];

  logic                    div_start;
  logic signed [SUM_W-1:0] div_in;
  div_ctl_t                div_ctl;
  logic signed [SUM_W-1:0] div_q;
  bpra_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
    .divisor((WIN_W+3)'(count)), .ctl(div_ctl), .quotient(div_q));

  // raster offset operand
  logic signed [17:0] rdx, rdy, roff;
  always_comb begin
    rdx = $signed({2'b0, ux});
    rdy = $signed({2'b0, uy});
    if (raster_mode == MODE_DIFF) begin
      rdx = rdx - $signed({2'b0, dx});
      rdy = rdy - $signed({2'b0, dy});
    end
    roff = (state == ST_OFF_X) ? rdx : rdy;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PROJ_X: begin mul_a = 33'(b_x) - 33'(a_x); mul_b = 32'(projection_ratio); end
      ST_PROJ_Y: begin mul_a = 33'(b_y) - 33'(a_y); mul_b = 32'(projection_ratio); end
      ST_OFF_X:  begin mul_a = 33'(roff - 18'(center_x)); mul_b = scale_x; end
      ST_OFF_Y:  begin mul_a = 33'(roff - 18'(center_y)); mul_b = scale_y; end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_PROJ_X;
      ST_PROJ_X: state_next = ST_PROJ_Y;
      ST_PROJ_Y: state_next = ST_READ;
      ST_READ:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_DIV_X;
      ST_DIV_X:  if (div_ctl.done) state_next = ST_DIV_Y;
      ST_DIV_Y:  if (div_ctl.done) state_next = ST_OFF_X;
      ST_OFF_X:  state_next = ST_OFF_Y;
      ST_OFF_Y:  state_next = ST_OUT;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // each division starts once the updated sum and count are registered
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    ram_we    = (state == ST_SUM);
    div_start = (state == ST_DIV_X || state == ST_DIV_Y) && !div_ctl.busy && !div_ctl.done;
    div_in    = (state == ST_DIV_X) ? sum_x : sum_y;
  end

  logic signed [SUM_W+8:0] proj_v;
  logic signed [31:0]      proj_s;
  logic                    proj_c;
  logic signed [SUM_W+8:0] off_v;
  logic signed [31:0]      out_s;
  logic                    out_c;
  always_comb begin
    proj_v = (state == ST_PROJ_X) ? (SUM_W+9)'(a_x) : (SUM_W+9)'(a_y);
    proj_v = proj_v + (SUM_W+9)'(mul_p >>> 16);
    proj_s = sat32(proj_v, proj_c);
    off_v  = (raster_mode == MODE_UP || raster_mode == MODE_DIFF) ?
             (SUM_W+9)'(mul_p >>> 8) : '0;
    out_s  = sat32(acc + off_v, out_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      raster_mode      <= 2'd0;
      projection_ratio <= 24'sd95822;
      window_length    <= 10'd500;
      center_x         <= 17'sd40000;
      center_y         <= 17'sd40000;
      scale_x          <= 32'sd40960000;
      scale_y          <= 32'sd40960000;
      sum_x            <= '0;
      sum_y            <= '0;
      fill_count       <= '0;
      oldest_pointer   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   raster_mode      <= cfg_data[1:0];
          REG_RATIO:  projection_ratio <= cfg_data[23:0];
          REG_WINDOW: begin
            window_length  <= cfg_data[9:0];
            sum_x          <= '0;
            sum_y          <= '0;
            fill_count     <= '0;
            oldest_pointer <= '0;
          end
          REG_CX:     center_x <= cfg_data[16:0];
          REG_CY:     center_y <= cfg_data[16:0];
          REG_SX:     scale_x  <= cfg_data;
          REG_SY:     scale_y  <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_SUM) begin
        if (full) begin
          sum_x <= sum_x + SUM_W'(px) - SUM_W'($signed(old_x));
          sum_y <= sum_y + SUM_W'(py) - SUM_W'($signed(old_y));
          oldest_pointer <= (CW'(oldest_pointer) + CW'(1) >= eff_w) ? '0 :
                            oldest_pointer + AW'(1);
          count <= eff_w;
        end else begin
          sum_x <= sum_x + SUM_W'(px);
          sum_y <= sum_y + SUM_W'(py);
          fill_count <= fill_count + CW'(1);
          count <= fill_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        a_x <= mon_a_x; a_y <= mon_a_y; b_x <= mon_b_x; b_y <= mon_b_y;
        ux <= up_raster_x; uy <= up_raster_y;
        dx <= down_raster_x; dy <= down_raster_y;
        clip <= 1'b0;
      end
      ST_PROJ_X: begin px <= proj_s; clip <= clip | proj_c; end
      ST_PROJ_Y: begin py <= proj_s; clip <= clip | proj_c; end
      ST_DIV_X:  if (div_ctl.done) avg_x <= div_q;
      ST_DIV_Y:  if (div_ctl.done) acc <= (SUM_W+9)'(avg_x);
      ST_OFF_X:  begin
        beam_x <= out_s; clip <= clip | out_c; acc <= (SUM_W+9)'(div_q);
      end
      ST_OFF_Y:  begin beam_y <= out_s; clipped <= clip | out_c; end
      default: ;
    endcase
  end

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accepted while busy");
  ap_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_ctl.busy) else $error("divider busy in idle");
  ap_fill: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_WINDOW)) else $error("fill count overflow");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

[rtl/bpra_ram.sv]
// generic single port ram with registered read
module bpra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/bpra_div.sv]
// serial restoring divider, signed dividend, positive divisor, truncating
module bpra_div import bpra_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [WIN_W+2:0]        divisor,
  output div_ctl_t                ctl,
  output logic signed [SUM_W-1:0] quotient
);
  logic [SUM_W-1:0] q;
  logic [SUM_W:0]   rem;
  logic [5:0]       cnt;
  logic             neg;
  logic             busy;
  logic             done;
  logic [SUM_W:0]   trial;
  logic [WIN_W+2:0] dv;

  assign trial = {rem[SUM_W-1:0], q[SUM_W-1]} - {{(SUM_W-WIN_W-2){1'b0}}, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_STEPS);
        neg  <= dividend[SUM_W-1];
        q    <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
        rem  <= '0;
        dv   <= divisor;
      end else if (busy) begin
        if (!trial[SUM_W]) begin
          rem <= trial;
          q   <= {q[SUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[SUM_W-1:0], q[SUM_W-1]};
          q   <= {q[SUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);
  assign ctl = '{start: start, busy: busy, done: done};
endmodule

[tb/tb_beam_position_raster_average_unit.sv]
// testbench for the beam position raster average unit, checked against a predictor
`timescale 1ns / 1ps

module tb_beam_position_raster_average_unit;
  import bpra_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAXW = MAX_WINDOW_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by;
    logic [15:0] urx, ury, drx, dry;
  } event_t;

  typedef struct packed {
    logic signed [31:0] bx, by;
    logic clip;
  } beam_t;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [31:0] mon_a_x, mon_a_y, mon_b_x, mon_b_y;
  logic [15:0] up_raster_x, up_raster_y, down_raster_x, down_raster_y;
  logic out_valid, out_stall;
  logic signed [31:0] beam_x, beam_y;
  logic clipped;

  beam_position_raster_average_unit dut (.*);

  // predictor state
  logic [1:0] p_mode;
  logic signed [23:0] p_ratio;
  logic [9:0] p_win;
  logic signed [16:0] p_cx, p_cy;
  logic signed [31:0] p_sx, p_sy;
  logic signed [31:0] ring_x [MAXW];
  logic signed [31:0] ring_y [MAXW];
  longint sum_x, sum_y;
  int fill, oldest;

  event_t pending_events[$];
  beam_t expected_beams[$];
  int mismatches;
  int idle_cycles;
  bit calm;
  int accepted;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat(longint v, ref bit c);
    if (v > 64'sd2147483647) begin c = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin c = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint project(longint a, longint b, ref bit c);
    longint d;
    d = (b - a) * longint'(p_ratio);
    return sat(a + floor_sh(d, 16), c);
  endfunction

  function automatic void restart_average();
    sum_x = 0; sum_y = 0; fill = 0; oldest = 0;
  endfunction

  function automatic void queue_event(event_t e);
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_MODE: p_mode = v[1:0];
      REG_RATIO: p_ratio = v[23:0];
      REG_WINDOW: begin p_win = v[9:0]; restart_average(); end
      REG_CX: p_cx = v[16:0];
      REG_CY: p_cy = v[16:0];
      REG_SX: p_sx = v;
      REG_SY: p_sy = v;
      default: ;
    endcase
  endfunction

  function automatic beam_t predict_beam(event_t e);
    bit c;
    longint px, py, cnt, avx, avy, ox, oy, rx, ry;
    int w, p;
    beam_t r;
    c = 0;
    px = project(longint'(e.ax), longint'(e.bx), c);
    py = project(longint'(e.ay), longint'(e.by), c);
    w = (p_win == 0) ? 1 : (p_win > MAXW) ? MAXW : int'(p_win);
    if (fill < w) begin
      ring_x[fill] = 32'(px); ring_y[fill] = 32'(py);
      sum_x += px; sum_y += py;
      fill++;
      cnt = fill;
    end else begin
      p = oldest % w;
      sum_x += px - longint'(ring_x[p]);
      sum_y += py - longint'(ring_y[p]);
      ring_x[p] = 32'(px); ring_y[p] = 32'(py);
      p++;
      oldest = (p >= w) ? 0 : p;
      cnt = w;
    end
    avx = sum_x / cnt;
    avy = sum_y / cnt;
    ox = 0; oy = 0;
    if (p_mode == MODE_UP || p_mode == MODE_DIFF) begin
      rx = longint'(e.urx); ry = longint'(e.ury);
      if (p_mode == MODE_DIFF) begin
        rx -= longint'(e.drx); ry -= longint'(e.dry);
      end
      rx -= longint'(p_cx); ry -= longint'(p_cy);
      ox = floor_sh(rx * longint'(p_sx), 8);
      oy = floor_sh(ry * longint'(p_sy), 8);
    end
    r.bx = 32'(sat(avx + ox, c));
    r.by = 32'(sat(avy + oy, c));
    r.clip = c;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(0, 2000000) - 1000000;
    endcase
  endfunction

  function automatic event_t rand_event(bit wild);
    event_t e;
    logic signed [31:0] base;
    base = $urandom_range(0, 200000) - 100000;
    if (wild) begin
      e.ax = rand_pos(); e.ay = rand_pos(); e.bx = rand_pos(); e.by = rand_pos();
    end else begin
      e.ax = base + $urandom_range(0, 2000) - 1000;
      e.ay = base + $urandom_range(0, 2000) - 1000;
      e.bx = base + $urandom_range(0, 2000) - 1000;
      e.by = base + $urandom_range(0, 2000) - 1000;
    end
    e.urx = 16'($urandom); e.ury = 16'($urandom);
    e.drx = 16'($urandom); e.dry = 16'($urandom);
    return e;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_events.delete(0);
        accepted++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (pending_events.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
        in_valid <= 1;
        {mon_a_x, mon_a_y, mon_b_x, mon_b_y, up_raster_x, up_raster_y,
         down_raster_x, down_raster_y} <= pending_events[0];
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    beam_t w;
    if (rst) begin
      out_stall <= 0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 12);
      if (in_valid && !in_stall) begin
        expected_beams.insert(expected_beams.size(), predict_beam(event_t'(
          {mon_a_x, mon_a_y, mon_b_x, mon_b_y, up_raster_x, up_raster_y,
           down_raster_x, down_raster_y})));
      end
      if (out_valid && !out_stall) begin
        idle_cycles <= 0;
        if (expected_beams.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          w = expected_beams[0];
          expected_beams.delete(0);
          if (beam_x !== w.bx) report_mismatch("beam_x", beam_x, w.bx);
          if (beam_y !== w.by) report_mismatch("beam_y", beam_y, w.by);
          if (clipped !== w.clip) report_mismatch("clipped", clipped, w.clip);
        end
      end else if (in_valid && !in_stall) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_register(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    apply_register(idx, v);
  endtask

  task automatic drain();
    wait (pending_events.size() == 0 && expected_beams.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic push_random(int n, bit wild_mostly);
    repeat (n) begin
      queue_event(rand_event(wild_mostly ? 1 : ($urandom_range(0, 9) == 0)));
    end
  endtask

  initial begin
    event_t e;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; out_stall = 0; calm = 0; mismatches = 0; idle_cycles = 0; accepted = 0;
    {mon_a_x, mon_a_y, mon_b_x, mon_b_y} = '0;
    {up_raster_x, up_raster_y, down_raster_x, down_raster_y} = '0;
    p_mode = 0; p_ratio = 95822; p_win = 500; p_cx = 40000; p_cy = 40000;
    p_sx = 40960000; p_sy = 40960000;
    restart_average();
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: reset settings, extremes, every mode
    e = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
          16'hffff, 16'h0000, 16'h0000, 16'hffff};
    queue_event(e);
    e = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
          16'h0000, 16'hffff, 16'hffff, 16'h0000};
    queue_event(e);
    queue_event('0);
    queue_event('1);
    drain();
    write_register(REG_MODE, MODE_UP);
    queue_event(e);
    queue_event('0);
    drain();
    write_register(REG_MODE, MODE_DIFF);
    write_register(REG_SX, 32'h7fffffff);
    write_register(REG_SY, 32'h80000000);
    write_register(REG_CX, 32'h0001ffff & -17'sd65535);
    write_register(REG_CY, 32'd65535);
    queue_event('1);
    queue_event('0);
    queue_event(e);
    drain();
    write_register(REG_MODE, MODE_UNUSED);
    write_register(REG_RATIO, 32'h00800000);
    write_register(REG_WINDOW, 0);
    push_random(4, 1);
    drain();
    write_register(REG_RATIO, 32'h007fffff);
    write_register(REG_WINDOW, 10'h3ff);
    push_random(4, 1);
    drain();

    // random phases with a spread of settings
    for (int ph = 0; ph < 12; ph++) begin
      write_register(REG_MODE, $urandom_range(0, 3));
      write_register(REG_RATIO, (ph % 4 == 0) ? $urandom : $urandom_range(0, 131072) - 65536);
      write_register(REG_WINDOW, (ph == 5) ? 512 : (ph == 7) ? 1 : $urandom_range(1, 24));
      write_register(REG_CX, $urandom);
      write_register(REG_CY, $urandom);
      write_register(REG_SX, (ph % 3 == 0) ? $urandom : $urandom_range(0, 20000) - 10000);
      write_register(REG_SY, (ph % 3 == 0) ? $urandom : $urandom_range(0, 20000) - 10000);
      calm = (ph == 3);
      push_random((ph == 5) ? 180 : 60, 0);
      drain();
    end
    calm = 0;
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
